// ===== hdl/rwt_pkg.sv =====
// Shared constants, types and helpers for the ripple wave table unit.
`default_nettype none
package rwt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int ENTRY_W = 64;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_MOVE   = 2'd1;
   localparam logic [1:0] OP_SPLASH = 2'd2;

   localparam logic [2:0] REG_WAVE_LIMIT  = 3'd0;
   localparam logic [2:0] REG_SPACING     = 3'd1;
   localparam logic [2:0] REG_TRAIL_SCALE = 3'd2;
   localparam logic [2:0] REG_DURATION    = 3'd3;
   localparam logic [2:0] REG_MAX_RADIUS  = 3'd4;
   localparam logic [2:0] REG_BASE_AMP    = 3'd5;
   localparam logic [2:0] REG_WAVE_LENGTH = 3'd6;

   localparam logic [4:0]  RST_WAVE_LIMIT  = 5'd8;
   localparam logic [15:0] RST_SPACING     = 16'd384;
   localparam logic [15:0] RST_TRAIL_SCALE = 16'd16384;
   localparam logic [15:0] RST_DURATION    = 16'd1000;
   localparam logic [15:0] RST_MAX_RADIUS  = 16'd3200;
   localparam logic [15:0] RST_BASE_AMP    = 16'd2048;
   localparam logic [15:0] RST_WAVE_LENGTH = 16'd6144;

   localparam logic [15:0] FULL_STRENGTH = 16'h8000;

   typedef struct packed {
      logic capture;
      logic dist_mul;
      logic evict;
      logic insert;
      logic clr_idx;
      logic tick_upd;
      logic tick_end;
      logic mul1;
      logic mul2;
      logic div_init;
      logic div_step;
      logic load_out;
      logic load_empty;
   } cmd_type;

   typedef struct packed {
      logic [1:0]    op;
      logic          count_zero;
      logic          j_zero;
      logic          dist_ok;
      logic          i_last;
      logic          div_done;
      logic          slot_free;
      logic [CW-1:0] count;
   } status_type;

   function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [CW-1:0] b);
      logic [SW-1:0] s;
      s = SW'(a) + SW'(b);
      if (s >= SW'(TABLE_DEPTH)) begin
         s = s - SW'(TABLE_DEPTH);
      end
      return s[IW-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/rwt_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none
module rwt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== hdl/rwt_ctrl.sv =====
// Sequencer for the wave table: decode, spawn, tick pass and emit pass.
`default_nettype none
module rwt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire rwt_pkg::status_type status,
   output rwt_pkg::cmd_type         cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_DCMP   = 4'd2;
   localparam logic [3:0] S_EVICT  = 4'd3;
   localparam logic [3:0] S_INS    = 4'd4;
   localparam logic [3:0] S_TRD    = 4'd5;
   localparam logic [3:0] S_TUPD   = 4'd6;
   localparam logic [3:0] S_TEND   = 4'd7;
   localparam logic [3:0] S_EMPTY  = 4'd8;
   localparam logic [3:0] S_ERD    = 4'd9;
   localparam logic [3:0] S_EMUL1  = 4'd10;
   localparam logic [3:0] S_EMUL2  = 4'd11;
   localparam logic [3:0] S_EDINIT = 4'd12;
   localparam logic [3:0] S_EDIV   = 4'd13;
   localparam logic [3:0] S_EOUT   = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.op)
               rwt_pkg::OP_TICK: begin
                  cmd.clr_idx = 1'b1;
                  state_in = status.count_zero ? S_IDLE : S_TRD;
               end
               rwt_pkg::OP_MOVE: begin
                  cmd.dist_mul = 1'b1;
                  state_in = S_DCMP;
               end
               rwt_pkg::OP_SPLASH: state_in = S_EVICT;
               default: state_in = S_IDLE;
            endcase
         end
         S_DCMP: state_in = status.dist_ok ? S_EVICT : S_IDLE;
         S_EVICT: begin
            cmd.evict = 1'b1;
            state_in = S_INS;
         end
         S_INS: begin
            cmd.insert = 1'b1;
            cmd.clr_idx = 1'b1;
            state_in = S_ERD;
         end
         S_TRD: state_in = S_TUPD;
         S_TUPD: begin
            cmd.tick_upd = 1'b1;
            state_in = status.i_last ? S_TEND : S_TRD;
         end
         S_TEND: begin
            cmd.tick_end = 1'b1;
            cmd.clr_idx = 1'b1;
            state_in = status.j_zero ? S_EMPTY : S_ERD;
         end
         S_EMPTY: begin
            if (status.slot_free) begin
               cmd.load_empty = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERD: state_in = S_EMUL1;
         S_EMUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_EMUL2;
         end
         S_EMUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_EDINIT;
         end
         S_EDINIT: begin
            cmd.div_init = 1'b1;
            state_in = S_EDIV;
         end
         S_EDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_EOUT;
            end
         end
         S_EOUT: begin
            if (status.slot_free) begin
               cmd.load_out = 1'b1;
               state_in = status.i_last ? S_IDLE : S_ERD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/rwt_dpath.sv =====
// Datapath: config registers, wave RAM, distance check, dividers, output register.
`default_nettype none
module rwt_dpath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic [47:0]         req_tdata,
   input  wire logic [1:0]          req_tuser,
   output logic [79:0]              rsp_tdata,
   output logic [0:0]               rsp_tuser,
   output logic                     rsp_tlast,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire rwt_pkg::cmd_type    cmd,
   output rwt_pkg::status_type      status
);
   localparam int IW = rwt_pkg::IW;
   localparam int CW = rwt_pkg::CW;

   logic [4:0]  mw_ff, mw_in;
   logic [15:0] spacing_ff, spacing_in, trail_ff, trail_in, dur_ff, dur_in;
   logic [15:0] mrad_ff, mrad_in, base_ff, base_in, wlen_ff, wlen_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] px_ff, px_in, py_ff, py_in, el_ff, el_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in;
   logic [15:0] lsx_ff, lsx_in, lsy_ff, lsy_in;
   logic [33:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [31:0] sp2_ff, sp2_in;
   logic [15:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [31:0] bs_ff, bs_in, rr_ff, rr_in, rnum_ff, rnum_in, dd_ff, dd_in;
   logic [63:0] anum_ff, anum_in, arem_ff, arem_in;
   logic [61:0] aden_ff, aden_in;
   logic [15:0] aq_ff, aq_in, rq_ff, rq_in;
   logic [31:0] rrem_ff, rrem_in;
   logic [46:0] rden_ff, rden_in;
   logic        sat_ff, sat_in;
   logic [4:0]  k_ff, k_in;
   logic        ov_ff, ov_in, ouser_ff, ouser_in, olast_ff, olast_in;
   logic [79:0] odata_ff, odata_in;

   logic [15:0] d_eff, age, strength, rdiff, age_n;
   logic [16:0] age_sum;
   logic        survive, slot_free;
   logic [CW-1:0] lim, n_drop;
   logic signed [16:0] dx, dy;
   logic signed [33:0] sqx_s, sqy_s;
   logic [34:0] dist2;
   logic        ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [63:0] ram_wdata, ram_rdata;

   rwt_ram #(.WIDTH(rwt_pkg::ENTRY_W), .DEPTH(rwt_pkg::TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign d_eff    = (dur_ff == 16'd0) ? 16'd1 : dur_ff;
   assign age      = ram_rdata[47:32];
   assign strength = ram_rdata[63:48];
   assign age_sum  = {1'b0, age} + {1'b0, el_ff};
   assign age_n    = age_sum[16] ? 16'hFFFF : age_sum[15:0];
   assign survive  = (age_n < d_eff);
   assign rdiff    = (age >= d_eff) ? (age - d_eff) : (d_eff - age);
   assign slot_free = !ov_ff || rsp_tready;
   assign ram_raddr = rwt_pkg::wrap_add(head_ff, i_ff);
   assign dist2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      if (mw_ff == 5'd0) begin
         lim = CW'(1);
      end else if (32'(mw_ff) > rwt_pkg::TABLE_DEPTH) begin
         lim = CW'(rwt_pkg::TABLE_DEPTH);
      end else begin
         lim = CW'(mw_ff);
      end
      n_drop = count_ff - lim + CW'(1);
      dx = {px_ff[15], px_ff} - {lsx_ff[15], lsx_ff};
      dy = {py_ff[15], py_ff} - {lsy_ff[15], lsy_ff};
      sqx_s = dx * dx;
      sqy_s = dy * dy;
   end

   always_comb begin
      mw_in = mw_ff; spacing_in = spacing_ff; trail_in = trail_ff; dur_in = dur_ff;
      mrad_in = mrad_ff; base_in = base_ff; wlen_in = wlen_ff;
      op_in = op_ff; px_in = px_ff; py_in = py_ff; el_in = el_ff;
      head_in = head_ff; count_in = count_ff; i_in = i_ff; j_in = j_ff;
      lsx_in = lsx_ff; lsy_in = lsy_ff;
      sqx_in = sqx_ff; sqy_in = sqy_ff; sp2_in = sp2_ff;
      ex_in = ex_ff; ey_in = ey_ff; bs_in = bs_ff; rr_in = rr_ff;
      rnum_in = rnum_ff; dd_in = dd_ff; anum_in = anum_ff;
      arem_in = arem_ff; aden_in = aden_ff; aq_in = aq_ff; sat_in = sat_ff;
      rrem_in = rrem_ff; rden_in = rden_ff; rq_in = rq_ff; k_in = k_ff;
      ov_in = ov_ff && !rsp_tready; ouser_in = ouser_ff; olast_in = olast_ff;
      odata_in = odata_ff;
      ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0;

      if (csr_we) begin
         case (csr_index)
            rwt_pkg::REG_WAVE_LIMIT:  mw_in = csr_wdata[4:0];
            rwt_pkg::REG_SPACING:     spacing_in = csr_wdata;
            rwt_pkg::REG_TRAIL_SCALE: trail_in = csr_wdata;
            rwt_pkg::REG_DURATION:    dur_in = csr_wdata;
            rwt_pkg::REG_MAX_RADIUS:  mrad_in = csr_wdata;
            rwt_pkg::REG_BASE_AMP:    base_in = csr_wdata;
            rwt_pkg::REG_WAVE_LENGTH: wlen_in = csr_wdata;
            default: ;
         endcase
      end
      if (cmd.capture) begin
         op_in = req_tuser;
         px_in = req_tdata[15:0];
         py_in = req_tdata[31:16];
         el_in = req_tdata[47:32];
      end
      if (cmd.dist_mul) begin
         sqx_in = 34'(sqx_s);
         sqy_in = 34'(sqy_s);
         sp2_in = spacing_ff * spacing_ff;
      end
      if (cmd.evict && (count_ff >= lim)) begin
         head_in = rwt_pkg::wrap_add(head_ff, n_drop);
         count_in = lim - CW'(1);
      end
      if (cmd.insert) begin
         ram_we = 1'b1;
         ram_waddr = rwt_pkg::wrap_add(head_ff, count_ff);
         ram_wdata = {(op_ff == rwt_pkg::OP_SPLASH) ? rwt_pkg::FULL_STRENGTH : trail_ff,
                      16'd0, py_ff, px_ff};
         count_in = count_ff + CW'(1);
         lsx_in = px_ff;
         lsy_in = py_ff;
      end
      if (cmd.clr_idx) begin
         i_in = '0;
         j_in = '0;
      end
      if (cmd.tick_upd) begin
         i_in = i_ff + CW'(1);
         if (survive) begin
            ram_we = 1'b1;
            ram_waddr = rwt_pkg::wrap_add(head_ff, j_ff);
            ram_wdata = {strength, age_n, ram_rdata[31:0]};
            j_in = j_ff + CW'(1);
         end
      end
      if (cmd.tick_end) begin
         count_in = j_ff;
      end
      if (cmd.mul1) begin
         ex_in = ram_rdata[15:0];
         ey_in = ram_rdata[31:16];
         bs_in = base_ff * strength;
         rr_in = rdiff * rdiff;
         rnum_in = mrad_ff * age;
         dd_in = d_eff * d_eff;
      end
      if (cmd.mul2) begin
         anum_in = 64'(bs_ff) * 64'(rr_ff);
      end
      if (cmd.div_init) begin
         sat_in = (anum_ff >= {1'b0, dd_ff, 31'd0});
         arem_in = anum_ff;
         aden_in = {dd_ff, 30'd0};
         rrem_in = rnum_ff;
         rden_in = {d_eff, 31'd0};
         k_in = 5'd31;
      end
      if (cmd.div_step) begin
         if (47'(rrem_ff) >= rden_ff) begin
            rrem_in = rrem_ff - rden_ff[31:0];
            rq_in = {rq_ff[14:0], 1'b1};
         end else begin
            rq_in = {rq_ff[14:0], 1'b0};
         end
         rden_in = rden_ff >> 1;
         if (!k_ff[4]) begin
            if (arem_ff >= 64'(aden_ff)) begin
               arem_in = arem_ff - 64'(aden_ff);
               aq_in = {aq_ff[14:0], 1'b1};
            end else begin
               aq_in = {aq_ff[14:0], 1'b0};
            end
            aden_in = aden_ff >> 1;
         end
         k_in = k_ff - 5'd1;
      end
      if (cmd.load_out) begin
         ov_in = 1'b1;
         ouser_in = 1'b1;
         olast_in = ((i_ff + CW'(1)) == count_ff);
         odata_in = {wlen_ff, sat_ff ? 16'hFFFF : aq_ff, rq_ff, ey_ff, ex_ff};
         i_in = i_ff + CW'(1);
      end
      if (cmd.load_empty) begin
         ov_in = 1'b1;
         ouser_in = 1'b0;
         olast_in = 1'b1;
         odata_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mw_ff <= rwt_pkg::RST_WAVE_LIMIT;
         spacing_ff <= rwt_pkg::RST_SPACING;
         trail_ff <= rwt_pkg::RST_TRAIL_SCALE;
         dur_ff <= rwt_pkg::RST_DURATION;
         mrad_ff <= rwt_pkg::RST_MAX_RADIUS;
         base_ff <= rwt_pkg::RST_BASE_AMP;
         wlen_ff <= rwt_pkg::RST_WAVE_LENGTH;
         head_ff <= '0;
         count_ff <= '0;
         lsx_ff <= '0;
         lsy_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         mw_ff <= mw_in;
         spacing_ff <= spacing_in;
         trail_ff <= trail_in;
         dur_ff <= dur_in;
         mrad_ff <= mrad_in;
         base_ff <= base_in;
         wlen_ff <= wlen_in;
         head_ff <= head_in;
         count_ff <= count_in;
         lsx_ff <= lsx_in;
         lsy_ff <= lsy_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; px_ff <= px_in; py_ff <= py_in; el_ff <= el_in;
      i_ff <= i_in; j_ff <= j_in;
      sqx_ff <= sqx_in; sqy_ff <= sqy_in; sp2_ff <= sp2_in;
      ex_ff <= ex_in; ey_ff <= ey_in; bs_ff <= bs_in; rr_ff <= rr_in;
      rnum_ff <= rnum_in; dd_ff <= dd_in; anum_ff <= anum_in;
      arem_ff <= arem_in; aden_ff <= aden_in; aq_ff <= aq_in; sat_ff <= sat_in;
      rrem_ff <= rrem_in; rden_ff <= rden_in; rq_ff <= rq_in; k_ff <= k_in;
      ouser_ff <= ouser_in; olast_ff <= olast_in; odata_ff <= odata_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;

   assign status.op         = op_ff;
   assign status.count_zero = (count_ff == '0);
   assign status.j_zero     = (j_ff == '0);
   assign status.dist_ok    = (dist2 >= 35'(sp2_ff));
   assign status.i_last     = ((i_ff + CW'(1)) == count_ff);
   assign status.div_done   = (k_ff == 5'd0);
   assign status.slot_free  = slot_free;
   assign status.count      = count_ff;
endmodule
`default_nettype wire

// ===== hdl/ripple_wave_table_unit.sv =====
// Ripple wave table unit: top level joining sequencer and datapath.
// A splash decodes, evicts and inserts before emitting; a move first checks the distance.
// Each wave goes through RAM read, two multiply stages, divider setup, a 32-step
// division (radius and amplitude in parallel) and output load, plus any output stall.
// A tick sweeps the table (read, update per wave); the next item is taken after the last.
// Reset (synchronous, active high) empties the table and restores register defaults.
`default_nettype none
module ripple_wave_table_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // pos_x, pos_y, elapsed
   input  wire logic [1:0]  req_tuser,   // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // wave x, wave y, radius, amplitude, wavelength_out
   output logic [0:0]       rsp_tuser,   // wave_valid
   output logic             rsp_tlast
);
   rwt_pkg::cmd_type    cmd;
   rwt_pkg::status_type status;

   rwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rwt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef ASSERT_OFF
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("empty-table item without tlast");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= rwt_pkg::CW'(rwt_pkg::TABLE_DEPTH))
      else $error("wave count above table depth");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready stayed high after accept");
`endif
endmodule
`default_nettype wire
